### rtl/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes, control/status structs and the grant-mask helper
// for the bitmap index allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int BIA_GROUPS      = 16;
    localparam int BIA_EPG         = 256;
    localparam int WORD_BITS       = 32;
    localparam int INDEX_BITS      = 12;
    localparam int INDEX_LIMIT     = 4096;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

    // reciprocal divide: exact for 12-bit indexes and group sizes from 9 up to 1024
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = 21;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;

    typedef struct packed {
        logic load;      // capture the accepted beat
        logic clr_step;  // write one zero word of the clearing pass
        logic sel_grp;   // pick lowest group with a free word
        logic rd_word;   // pick lowest free word, read it
        logic alloc_wr;  // set lowest free bit, update summary and count
        logic rel_div;   // split release index: group
        logic rel_rd;    // word address and bit, read it
        logic rel_wr;    // test and clear the bit
    } bia_cmd_t;

    typedef struct packed {
        logic clr_last;  // clearing pass at its last word
        logic grp_any;   // some group still has a grantable entry
        logic rel_ok;    // release index lies inside the table
    } bia_stat_t;

    // Bits of word w in group g that may ever be granted.
    function automatic logic [WORD_BITS-1:0] grant_mask(input int epg, input int g,
                                                        input int w);
        int lim_grp;
        int lim_idx;
        int n;
        lim_grp = epg - w * WORD_BITS;
        lim_idx = INDEX_LIMIT - g * epg - w * WORD_BITS;
        n = WORD_BITS;
        if (lim_grp < n) n = lim_grp;
        if (lim_idx < n) n = lim_idx;
        if (n <= 0) begin
            return '0;
        end else if (n >= WORD_BITS) begin
            return FULL_WORD;
        end else begin
            return (WORD_BITS'(1) << n) - WORD_BITS'(1);
        end
    endfunction

endpackage

### rtl/bia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bia_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_datapath
// Bitmap RAM, full-word summary, group counts, index math and result regs.
// ----------------------------------------------------------------------------
module bia_datapath #(
    parameter int GROUPS            = 16,
    parameter int ENTRIES_PER_GROUP = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bia_pkg::bia_cmd_t          cmd,
    input  logic [bia_pkg::INDEX_BITS-1:0] in_index,
    output bia_pkg::bia_stat_t         stat,
    output logic [1:0]                 res_status,
    output logic [bia_pkg::INDEX_BITS-1:0] res_index
);
    import bia_pkg::*;

    localparam int EPG    = ENTRIES_PER_GROUP;
    localparam int WPG    = (EPG + WORD_BITS - 1) / WORD_BITS;
    localparam int NWORDS = GROUPS * WPG;
    localparam int TOTAL  = GROUPS * EPG;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WW     = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int CW     = $clog2(EPG + 1);
    localparam int BW     = $clog2(WORD_BITS);
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((1 << RECIP_SHIFT) + EPG - 1) / EPG);

    // words with nothing grantable start out marked full
    function automatic logic [NWORDS-1:0] full_init();
        logic [NWORDS-1:0] v;
        v = '0;
        for (int i = 0; i < NWORDS; i++) begin
            v[i] = (grant_mask(EPG, i / WPG, i % WPG) == '0);
        end
        return v;
    endfunction
    localparam logic [NWORDS-1:0] FULL_INIT = full_init();

    logic [INDEX_BITS-1:0] idx_reg;
    logic [GW-1:0]         grp_reg;
    logic [WW-1:0]         word_reg;
    logic [BW-1:0]         bit_reg;
    logic [AW-1:0]         wi_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [NWORDS-1:0]     word_full_reg;
    logic [CW-1:0]         count_reg [GROUPS];
    logic [1:0]            res_status_reg;
    logic [INDEX_BITS-1:0] res_index_reg;

    // group search
    logic [WPG-1:0]    row_full [GROUPS];
    logic [GROUPS-1:0] grp_avail;
    logic [GROUPS-1:0] grp_1h;
    logic [GW-1:0]     grp_enc;

    always_comb begin
        grp_enc = '0;
        for (int g = 0; g < GROUPS; g++) begin
            row_full[g]  = word_full_reg[g * WPG +: WPG];
            grp_avail[g] = (count_reg[g] < CW'(EPG)) && !(&row_full[g]);
        end
        grp_1h = grp_avail & (~grp_avail + GROUPS'(1));
        for (int g = 0; g < GROUPS; g++) begin
            if (grp_1h[g]) grp_enc |= GW'(g);
        end
    end

    // word search inside the chosen group
    logic [WPG-1:0] word_free;
    logic [WPG-1:0] word_1h;
    logic [WW-1:0]  word_enc;
    logic [AW-1:0]  wi_alloc;

    always_comb begin
        word_enc  = '0;
        word_free = ~row_full[grp_reg];
        word_1h   = word_free & (~word_free + WPG'(1));
        for (int w = 0; w < WPG; w++) begin
            if (word_1h[w]) word_enc |= WW'(w);
        end
        wi_alloc = AW'(grp_reg * WPG + word_enc);
    end

    // release index split
    logic [INDEX_BITS+RECIP_BITS-1:0] quot_prod;
    logic [INDEX_BITS-1:0]            rel_off;
    logic [AW-1:0]                    wi_rel;

    assign quot_prod = {{RECIP_BITS{1'b0}}, idx_reg} * RECIP;
    assign rel_off   = idx_reg - INDEX_BITS'(grp_reg * EPG);
    assign wi_rel    = AW'(grp_reg * WPG + (rel_off >> BW));
    assign stat.rel_ok   = (32'(idx_reg) < TOTAL);
    assign stat.grp_any  = |grp_avail;
    assign stat.clr_last = (clr_addr_reg == AW'(NWORDS - 1));

    // bit level
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] bit_1h;
    logic [BW-1:0]        bit_enc;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] rel_1h;
    logic                 rel_hit;

    always_comb begin
        bit_enc   = '0;
        mask      = grant_mask(EPG, int'(grp_reg), int'(word_reg));
        free_bits = ~(rd_data | ~mask);
        bit_1h    = free_bits & (~free_bits + WORD_BITS'(1));
        for (int b = 0; b < WORD_BITS; b++) begin
            if (bit_1h[b]) bit_enc |= BW'(b);
        end
        alloc_word = rd_data | bit_1h;
        rel_1h     = WORD_BITS'(1) << bit_reg;
        rel_hit    = |(rd_data & rel_1h);
    end

    // RAM ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = alloc_word;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (cmd.alloc_wr) begin
            ram_we = 1'b1;
        end else if (cmd.rel_wr && rel_hit) begin
            ram_we    = 1'b1;
            ram_wdata = rd_data & ~rel_1h;
        end
        ram_raddr = cmd.rel_rd ? wi_rel : wi_alloc;
    end

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // control-side state: summary, counts, clear pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            word_full_reg <= FULL_INIT;
            for (int g = 0; g < GROUPS; g++) count_reg[g] <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.alloc_wr) begin
                word_full_reg[wi_reg] <= &(alloc_word | ~mask);
                count_reg[grp_reg]    <= count_reg[grp_reg] + CW'(1);
            end
            if (cmd.rel_wr && rel_hit) begin
                word_full_reg[wi_reg] <= 1'b0;
                if (count_reg[grp_reg] != '0) begin
                    count_reg[grp_reg] <= count_reg[grp_reg] - CW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg <= in_index;
        end
        if (cmd.sel_grp) begin
            grp_reg <= grp_enc;
            if (!stat.grp_any) begin
                res_status_reg <= ST_NOFREE;
                res_index_reg  <= '0;
            end
        end
        if (cmd.rd_word) begin
            word_reg <= word_enc;
            wi_reg   <= wi_alloc;
        end
        if (cmd.alloc_wr) begin
            res_status_reg <= ST_DONE;
            res_index_reg  <= INDEX_BITS'(grp_reg * EPG + word_reg * WORD_BITS + bit_enc);
        end
        if (cmd.rel_div) begin
            grp_reg <= quot_prod[RECIP_SHIFT +: GW];
            if (!stat.rel_ok) begin
                res_status_reg <= ST_NOTALLOC;
                res_index_reg  <= '0;
            end
        end
        if (cmd.rel_rd) begin
            wi_reg  <= wi_rel;
            bit_reg <= rel_off[BW-1:0];
        end
        if (cmd.rel_wr) begin
            res_status_reg <= rel_hit ? ST_DONE : ST_NOTALLOC;
            res_index_reg  <= '0;
        end
    end

    assign res_status = res_status_reg;
    assign res_index  = res_index_reg;

    // a chosen group really has a free word
    a_grp_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sel_grp && stat.grp_any) |=> !(&row_full[grp_reg]))
        else $error("selected group has no free word");

    // the word read for an allocate holds a grantable zero
    a_alloc_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_wr |-> (free_bits != '0))
        else $error("allocate word has no free bit");

    // group count stays in range on allocate
    a_count_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_wr |-> (count_reg[grp_reg] < CW'(EPG)))
        else $error("allocate into full group");

    // a successful release leaves its word marked not full
    a_rel_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rel_wr && rel_hit) |=> !word_full_reg[$past(wi_reg)])
        else $error("summary not cleared after release");

endmodule

### rtl/bia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer: clearing pass, allocate and release steps, result hand-off.
// ----------------------------------------------------------------------------
module bia_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_kind,
    output logic               in_ready,
    input  logic               out_busy,
    output logic               out_load,
    input  bia_pkg::bia_stat_t stat,
    output bia_pkg::bia_cmd_t  cmd
);
    import bia_pkg::*;

    typedef enum logic [3:0] {
        CLEAR, IDLE, A_GRP, A_WORD, A_BIT, R_DIV, R_ADDR, R_BIT, OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = IDLE;
            end
            IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid) state_next = (in_kind == KIND_RELEASE) ? R_DIV : A_GRP;
            end
            A_GRP: begin
                cmd.sel_grp = 1'b1;
                state_next  = stat.grp_any ? A_WORD : OUT;
            end
            A_WORD: begin
                cmd.rd_word = 1'b1;
                state_next  = A_BIT;
            end
            A_BIT: begin
                cmd.alloc_wr = 1'b1;
                state_next   = OUT;
            end
            R_DIV: begin
                cmd.rel_div = 1'b1;
                state_next  = stat.rel_ok ? R_ADDR : OUT;
            end
            R_ADDR: begin
                cmd.rel_rd = 1'b1;
                state_next = R_BIT;
            end
            R_BIT: begin
                cmd.rel_wr = 1'b1;
                state_next = OUT;
            end
            OUT: begin
                out_load = !out_busy;
                if (!out_busy) state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bitmap_index_allocator_top.sv
`timescale 1ns / 1ps
// Steps: an allocate runs group select, word read and bit set; a release runs
//   index split, word read and bit clear; a full table or a release index past
//   the table goes straight to the result step. One beat is worked at a time,
//   as each is a read-modify-write of a bitmap word through the registered RAM read port.
// Reset: synchronous, active-low aresetn; a clearing pass then zeroes every
//   bitmap word (128 words at the defaults) while s_tready is held low.
// ----------------------------------------------------------------------------
// bitmap_index_allocator_top
// First-fit index allocator over an in-use bitmap with per-group counts.
// ----------------------------------------------------------------------------
module bitmap_index_allocator_top #(
    parameter int GROUPS            = bia_pkg::BIA_GROUPS,
    parameter int ENTRIES_PER_GROUP = bia_pkg::BIA_EPG
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] entry_index, [15:12] zero
    input  logic        s_tuser,   // [0] kind: 0 allocate, 1 release
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [13:2] granted_index, [15:14] zero
);
    import bia_pkg::*;

    bia_cmd_t              cmd;
    bia_stat_t             stat;
    logic                  out_load;
    logic                  out_busy;
    logic [1:0]            res_status;
    logic [INDEX_BITS-1:0] res_index;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    // Output register parts the two sides: the sequencer can accept and
    // work the next beat while a result is still waiting here. It only
    // stalls in its hand-off step if this register is still occupied.
    assign out_busy = m_tvalid_reg && !m_tready;

    // Sequencer: owns the handshake on the request side and steps the
    // datapath through the allocate or release sequence.
    bia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .out_busy (out_busy),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: bitmap RAM plus a full-word summary in flops, so a search
    // is lowest non-full group, then lowest non-full word, then one RAM
    // read and a lowest-zero pick in that word.
    bia_datapath #(
        .GROUPS            (GROUPS),
        .ENTRIES_PER_GROUP (ENTRIES_PER_GROUP)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_index   (s_tdata[INDEX_BITS-1:0]),
        .stat       (stat),
        .res_status (res_status),
        .res_index  (res_index)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, res_index, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/bia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_checker
// Watches both channels of the index allocator. It keeps its own bitmap and
// group counts, works out the answer for each request beat, and compares
// every result beat with the oldest answer still due.
// ----------------------------------------------------------------------------
module bia_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] entry_index, [15:12] zero
    input  logic        s_tuser,   // [0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [1:0] status, [13:2] granted_index, [15:14] zero
    output int          fail_count,
    output int          results_due,
    output int          grants_made,
    output int          full_answers,
    output int          releases_done,
    output int          stray_releases
);
    import bia_pkg::*;

    localparam int WPG    = (BIA_EPG + WORD_BITS - 1) / WORD_BITS;
    localparam int NWORDS = BIA_GROUPS * WPG;
    localparam int TOTAL  = BIA_GROUPS * BIA_EPG;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [1:0]            status;
        logic [INDEX_BITS-1:0] granted;
    } grant_t;

    logic [WORD_BITS-1:0] inuse_map [NWORDS];
    int unsigned          grp_used [BIA_GROUPS];
    grant_t               grants_due [$];
    int                   errors;
    int                   n_grant, n_full, n_rel, n_stray;
    int                   result_no;

    // lowest free index: skip full groups, then all-ones words, then LSB first
    function automatic grant_t take_lowest();
        grant_t r;
        int     off;
        int     idx;
        r.status  = ST_NOFREE;
        r.granted = '0;
        for (int g = 0; g < BIA_GROUPS; g++) begin
            if (grp_used[g] >= BIA_EPG) continue;
            for (int w = 0; w < WPG; w++) begin
                if (inuse_map[g * WPG + w] == FULL_WORD) continue;
                for (int b = 0; b < WORD_BITS; b++) begin
                    off = w * WORD_BITS + b;
                    idx = g * BIA_EPG + off;
                    if (off >= BIA_EPG || idx >= INDEX_LIMIT) break;
                    if (!inuse_map[g * WPG + w][b]) begin
                        inuse_map[g * WPG + w][b] = 1'b1;
                        grp_used[g]++;
                        r.status  = ST_DONE;
                        r.granted = INDEX_BITS'(idx);
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    // clear one entry; a free or out-of-table index leaves everything alone
    function automatic logic [1:0] free_entry(input logic [INDEX_BITS-1:0] idx);
        int g;
        int off;
        int wi;
        if (int'(idx) >= TOTAL) return ST_NOTALLOC;
        g   = int'(idx) / BIA_EPG;
        off = int'(idx) % BIA_EPG;
        wi  = g * WPG + off / WORD_BITS;
        if (!inuse_map[wi][off % WORD_BITS]) return ST_NOTALLOC;
        inuse_map[wi][off % WORD_BITS] = 1'b0;
        if (grp_used[g] > 0) grp_used[g]--;
        return ST_DONE;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (!aresetn) begin
            for (int i = 0; i < NWORDS; i++) inuse_map[i] = '0;
            for (int i = 0; i < BIA_GROUPS; i++) grp_used[i] = 0;
            grants_due.delete();
            errors    = 0;
            n_grant   = 0;
            n_full    = 0;
            n_rel     = 0;
            n_stray   = 0;
            result_no = 0;
        end else begin
            // result side first, so a beat can never match its own request
            if (m_tvalid && m_tready) begin
                got.status  = m_tdata[1:0];
                got.granted = m_tdata[13:2];
                if (grants_due.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("[%0t] result beat %0d arrived with nothing due: status %0d index %0d",
                                 $realtime, result_no, got.status, got.granted);
                end else begin
                    want = grants_due.pop_front();
                    if (got.status !== want.status || got.granted !== want.granted) begin
                        errors++;
                        if (errors <= SHOW_LIMIT)
                            $display("[%0t] result beat %0d: expected status %0d index %0d, got status %0d index %0d",
                                     $realtime, result_no, want.status, want.granted,
                                     got.status, got.granted);
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_RELEASE) begin
                    want.status  = free_entry(s_tdata[INDEX_BITS-1:0]);
                    want.granted = '0;
                    if (want.status == ST_DONE) n_rel++;
                    else n_stray++;
                end else begin
                    want = take_lowest();
                    if (want.status == ST_DONE) n_grant++;
                    else n_full++;
                end
                grants_due.push_back(want);
            end
        end
        fail_count     <= errors;
        results_due    <= grants_due.size();
        grants_made    <= n_grant;
        full_answers   <= n_full;
        releases_done  <= n_rel;
        stray_releases <= n_stray;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bitmap index allocator. Directed beats first,
// then rounds of random allocate/release traffic, then a closing mixed run.
// All checking lives in bia_checker.
// ----------------------------------------------------------------------------
module tb;
    import bia_pkg::*;

    localparam int TABLE_SIZE   = BIA_GROUPS * BIA_EPG;
    localparam int RANDOM_BEATS = 1000;
    localparam int TAIL_BEATS   = 180;
    localparam int HOLD_CYCLES  = 400;   // long result-side back-pressure
    localparam int IDLE_PCT     = 32;
    // no-accept cycles before we give up: covers the clearing pass after
    // reset (128 words) and the hold-off with lots of margin
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 20;    // quiet wait after the final drain

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [11:0] entry_index, [15:12] zero
    logic        s_tuser  = 1'b0; // [0] kind: 0 allocate, 1 release
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [1:0] status, [13:2] granted_index, [15:14] zero

    int fail_count, results_due;
    int grants_made, full_answers, releases_done, stray_releases;

    // stimulus-owned knobs, read by the result-side process
    logic calm      = 1'b0;  // no idling on either side while set
    int   hold_asks = 0;     // bump to request one long hold-off
    int   hold_seen = 0;
    int   hold_left = 0;

    int beats_sent = 0;
    int live_guess = 0;      // rough count of entries in use, steers releases
    int quiet      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bitmap_index_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bia_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .results_due    (results_due),
        .grants_made    (grants_made),
        .full_answers   (full_answers),
        .releases_done  (releases_done),
        .stray_releases (stray_releases)
    );

    // Result side. A hold-off request wins over everything and runs for
    // HOLD_CYCLES counted here; otherwise ready drops ~32% of the time
    // unless the stimulus has asked for a calm stretch.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: any beat on either channel resets it. Also bounds the final
    // drain, so a lost result ends the run here.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("[%0t] no beat accepted for %0d cycles, %0d results still due",
                     $realtime, STALL_LIMIT, results_due);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // One request beat. Random idle cycles go in front; valid stays up
    // from one beat to the next when there is no gap.
    task automatic send_beat(input logic kind, input logic [INDEX_BITS-1:0] idx);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (kind == KIND_ALLOC) begin
            if (live_guess < TABLE_SIZE) live_guess++;
        end else if (live_guess > 0) begin
            live_guess--;
        end
    endtask

    // Stop sending and wait until every answer has come back. The checker
    // publishes its count through a register, hence the first wait.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // Mostly indexes that are likely in use (allocation is lowest-first,
    // so they sit near the bottom), sometimes anywhere in the 12-bit range.
    function automatic logic [INDEX_BITS-1:0] pick_victim();
        int top;
        top = live_guess + 31;
        if (top > TABLE_SIZE - 1) top = TABLE_SIZE - 1;
        if ($urandom_range(0, 99) < 85)
            return INDEX_BITS'($urandom_range(0, top));
        return INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
    endfunction

    initial begin
        int p_alloc;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed: empty-table releases, reuse of the lowest hole,
        //      double release, index extremes and alternating bit patterns
        send_beat(KIND_RELEASE, 12'd0);        // free entry
        send_beat(KIND_RELEASE, 12'hfff);      // free entry, top index
        send_beat(KIND_ALLOC, 12'hfff);        // index ignored -> 0
        send_beat(KIND_ALLOC, 12'd0);          // -> 1
        send_beat(KIND_ALLOC, 12'h555);        // -> 2
        send_beat(KIND_RELEASE, 12'd1);
        send_beat(KIND_RELEASE, 12'd1);        // second time: not allocated
        send_beat(KIND_ALLOC, 12'd0);          // hole at 1 comes back first
        send_beat(KIND_RELEASE, 12'd0);
        send_beat(KIND_RELEASE, 12'd2);
        send_beat(KIND_ALLOC, 12'd0);          // -> 0
        send_beat(KIND_ALLOC, 12'd0);          // -> 2
        send_beat(KIND_ALLOC, 12'd0);          // -> 3
        send_beat(KIND_RELEASE, 12'haaa);      // free, high group
        send_beat(KIND_RELEASE, 12'h555);      // free
        send_beat(KIND_RELEASE, 12'd3);
        send_beat(KIND_RELEASE, 12'd0);
        send_beat(KIND_ALLOC, 12'd0);          // -> 0
        send_beat(KIND_ALLOC, 12'd0);          // -> 3
        send_beat(KIND_ALLOC, 12'd0);          // -> 4
        drain();

        // ---- random rounds; the allocate share moves per round so the
        //      table grows and shrinks. Pressure points sit mid-stream.
        p_alloc = 55;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) p_alloc = $urandom_range(35, 75);
            if (n == 300) calm <= 1'b1;
            if (n == 500) calm <= 1'b0;
            if (n == 700) hold_asks <= hold_asks + 1;   // result side stalls,
                                                        // we keep offering
            if (n == 900) drain();                      // sender pause
            if ($urandom_range(0, 99) < p_alloc)
                send_beat(KIND_ALLOC, INDEX_BITS'($urandom));
            else
                send_beat(KIND_RELEASE, pick_victim());
        end
        drain();

        // ---- closing mix: releases anywhere in the table punch holes
        //      that later allocates must refill lowest first
        for (int n = 0; n < TAIL_BEATS; n++) begin
            if ($urandom_range(0, 99) < 50)
                send_beat(KIND_ALLOC, INDEX_BITS'($urandom));
            else if ($urandom_range(0, 99) < 50)
                send_beat(KIND_RELEASE, pick_victim());
            else
                send_beat(KIND_RELEASE, INDEX_BITS'($urandom_range(0, TABLE_SIZE - 1)));
        end

        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d request beats: %0d grants, %0d table-full answers,",
                 beats_sent, grants_made, full_answers);
        $display("%0d releases and %0d releases of free entries, with stalls both sides.",
                 releases_done, stray_releases);
        if (fail_count == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, results_due);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
